// ===== rtl/sdb64_pkg.sv =====
package sdb64_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } item_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = 2;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [6:0]  EqChar = 7'h3D;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26)      r = 7'd65 + {1'b0, v};
    else if (v < 6'd52) r = 7'd71 + {1'b0, v};
    else if (v < 6'd62) r = {1'b0, v} - 7'd4;
    else if (v == 6'd62) r = 7'd43;
    else                 r = 7'd47;
    return r;
  endfunction

endpackage

// ===== rtl/sdb64_front.sv =====
// Input skid-free queue: accepts items, drops idle ones.
module sdb64_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdb64_pkg::item_t    in_item_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output sdb64_pkg::item_t    q_item_o
);
  sdb64_pkg::item_t mem_q [sdb64_pkg::QDepth];
  logic [sdb64_pkg::QAw-1:0] wp_q, rp_q;
  logic [sdb64_pkg::QAw:0]   cnt_q;
  logic push, pop;

  assign in_stall_o = (cnt_q == 3'(sdb64_pkg::QDepth));
  assign push = in_valid_i && !in_stall_o && (in_item_i.present || in_item_i.eom);
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_pop_i;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

// ===== rtl/sdb64_back.sv =====
// Block packing, padding, 80-round compression and base64 output.
module sdb64_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  sdb64_pkg::item_t q_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [6:0]       b64_char_o,
  output logic             last_char_o
);
  localparam logic [2:0] SIdle = 3'd0, SPad = 3'd1, SComp = 3'd2,
                         SFin = 3'd3, SOut = 3'd4;

  logic [2:0]   st_q;
  logic [31:0]  h_q [5];
  logic [31:0]  w_q [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [63:0]  len_q;
  logic [5:0]   fill_q;
  logic [6:0]   rnd_q;
  logic         eom_q;
  logic [1:0]   pad_q;   // 0: mark next, 1: zeros, 2: length
  logic [4:0]   cidx_q;
  logic [167:0] sh_q;
  logic         ov_q;

  logic [7:0]  pb;
  logic        put;
  logic [31:0] wt, wnew, f, k, tmp;

  // byte to put this cycle
  always_comb begin
    pb = 8'h00; put = 1'b0;
    if (st_q == SIdle) begin
      put = q_valid_i && q_item_i.present;
      pb  = q_item_i.data;
    end else if (st_q == SPad) begin
      put = 1'b1;
      if (pad_q == 2'd0)      pb = sdb64_pkg::PadMark;
      else if (pad_q == 2'd2) pb = len_q[8*(7-(fill_q[2:0]))+:8];
    end
  end
  assign q_pop_o = (st_q == SIdle) && q_valid_i;

  assign wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign wt = (rnd_q < 7'd16) ? w_q[0] : {wnew[30:0], wnew[31]};
  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = sdb64_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = sdb64_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = sdb64_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q; k = sdb64_pkg::K3;
    end
  end
  assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;

  assign out_valid_o = ov_q;
  assign b64_char_o  = (cidx_q == 5'd27) ? sdb64_pkg::EqChar : sdb64_pkg::b64_char(sh_q[167:162]);
  assign last_char_o = (cidx_q == 5'd27);

  always_ff @(posedge clk_i) begin
    if (put) begin
      if (fill_q[1:0] == 2'd0) w_q[fill_q[5:2]] <= {pb, 24'h0};
      else w_q[fill_q[5:2]][8*(3-fill_q[1:0])+:8] <= pb;
    end
    if (st_q == SComp) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      a_q <= tmp; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q; e_q <= d_q;
    end else begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; fill_q <= '0; len_q <= '0; rnd_q <= '0; eom_q <= 1'b0;
      pad_q <= '0; cidx_q <= '0; sh_q <= '0; ov_q <= 1'b0;
      h_q[0] <= sdb64_pkg::H0; h_q[1] <= sdb64_pkg::H1; h_q[2] <= sdb64_pkg::H2;
      h_q[3] <= sdb64_pkg::H3; h_q[4] <= sdb64_pkg::H4;
    end else begin
      if (put) fill_q <= fill_q + 6'd1;
      case (st_q)
        SIdle: if (q_valid_i) begin
          if (q_item_i.present) len_q <= len_q + 64'd8;
          eom_q <= q_item_i.eom;
          pad_q <= 2'd0;
          if (q_item_i.present && fill_q == 6'd63) st_q <= SComp;
          else if (q_item_i.eom) st_q <= SPad;
        end
        SPad: begin
          if (pad_q == 2'd0 || (pad_q == 2'd1 && fill_q == 6'd55)) pad_q <= pad_q + 2'd1;
          if (pad_q != 2'd0 && pad_q == 2'd1 && fill_q == 6'd55) pad_q <= 2'd2;
          if (fill_q == 6'd63) st_q <= SComp;
          else if (pad_q == 2'd0 && fill_q == 6'd55) pad_q <= 2'd2;
        end
        SComp: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) begin
            rnd_q <= '0;
            h_q[0] <= h_q[0] + tmp; h_q[1] <= h_q[1] + a_q;
            h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
            h_q[3] <= h_q[3] + c_q; h_q[4] <= h_q[4] + d_q;
            if (!eom_q) st_q <= SIdle;
            else if (pad_q == 2'd2) st_q <= SFin;
            else st_q <= SPad;
          end
        end
        SFin: begin
          sh_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], 8'h00};
          cidx_q <= '0; ov_q <= 1'b1; st_q <= SOut;
        end
        SOut: if (!out_stall_i) begin
          sh_q <= {sh_q[161:0], 6'h0};
          cidx_q <= cidx_q + 5'd1;
          if (cidx_q == 5'd27) begin
            ov_q <= 1'b0; st_q <= SIdle; len_q <= '0; eom_q <= 1'b0;
            h_q[0] <= sdb64_pkg::H0; h_q[1] <= sdb64_pkg::H1; h_q[2] <= sdb64_pkg::H2;
            h_q[3] <= sdb64_pkg::H3; h_q[4] <= sdb64_pkg::H4;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== rtl/sha1_digest_base64_core.sv =====
// Channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | msg_byte_i, byte_present_i, end_of_message_i
// out     | out_valid_o| out_stall_i | b64_char_o, last_char_o
// The back end takes one byte per cycle while idle; each full block is then compressed in the round unit.
// A closing item pads one byte a cycle, compresses one or two blocks, then
// sends 28 characters, one per cycle without stall. A four-entry queue takes
// items while the round unit works. Reset restores the SHA-1 initial chain.
module sha1_digest_base64_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] msg_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] b64_char_o,
  output logic       last_char_o
);
  sdb64_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;

  assign in_item.data = msg_byte_i;
  assign in_item.present = byte_present_i;
  assign in_item.eom = end_of_message_i;

  sdb64_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  sdb64_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .b64_char_o, .last_char_o
  );
endmodule

// ===== test/testbench.sv =====
module testbench;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] msg_byte_i = 8'h00;
  logic       byte_present_i = 1'b0;
  logic       end_of_message_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] b64_char_o;
  logic       last_char_o;

  sha1_digest_base64_core dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } b64_out_t;

  typedef struct {
    sdb64_pkg::item_t item;
    string digest;  // empty: use the running hash model
  } row_t;

  // running SHA-1 state
  logic [31:0] chain[5];
  logic [31:0] words[16];
  logic [63:0] bit_count;
  logic [5:0]  fill;

  b64_out_t digest_q[$];
  int errors = 0;
  int msgs_done = 0;
  int bytes_sent = 0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [6:0] to_b64(input logic [5:0] v);
    if (v < 26) return 7'(8'd65 + v);
    if (v < 52) return 7'(8'd97 + v - 26);
    if (v < 62) return 7'(8'd48 + v - 52);
    if (v == 62) return 7'd43;
    return 7'd47;
  endfunction

  task automatic hash_init();
    chain[0] = 32'h67452301; chain[1] = 32'hEFCDAB89; chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476; chain[4] = 32'hC3D2E1F0;
    foreach (words[i]) words[i] = '0;
    bit_count = '0;
    fill = '0;
  endtask

  task automatic compress();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t;
    w = words;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16)
        w[r & 15] = rol(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[r & 15];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic absorb(input logic [7:0] v);
    if (fill[1:0] == 2'd0) words[fill[5:2]] = {v, 24'h0};
    else words[fill[5:2]] |= 32'(v) << (8 * (3 - fill[1:0]));
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endtask

  // advance the hash model by one accepted item, queueing any digest text
  task automatic hash_item(input sdb64_pkg::item_t it, input string typed);
    logic [63:0]  len;
    logic [159:0] h;
    logic [167:0] bits;
    logic [6:0]   ch;
    if (it.present) begin
      absorb(it.data);
      bit_count += 64'd8;
      bytes_sent++;
    end
    if (it.eom) begin
      len = bit_count;
      absorb(8'h80);
      while (fill != 6'd56) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(len[63 - 8 * i -: 8]);
      h = {chain[0], chain[1], chain[2], chain[3], chain[4]};
      bits = {h, 8'h00};
      for (int i = 0; i < 28; i++) begin
        ch = (i == 27) ? 7'h3D : to_b64(bits[167 - 6 * i -: 6]);
        if (typed.len() == 28) ch = 7'(typed[i]);
        digest_q.push_back('{ch, i == 27});
      end
      msgs_done++;
      hash_init();
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
  endtask

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 23);
  endfunction

  task automatic send(input sdb64_pkg::item_t it, input string typed);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    msg_byte_i       <= it.data;
    byte_present_i   <= it.present;
    end_of_message_i <= it.eom;
    do @(posedge clk_i); while (in_stall_o);
    hash_item(it, typed);
    @(negedge clk_i);
  endtask

  // out side: stall at random, check every transfer
  always @(negedge clk_i) out_stall_i <= idle_now();

  always @(posedge clk_i) begin
    b64_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report("unexpected char", b64_char_o, 0);
      end else begin
        want = digest_q.pop_front();
        if (b64_char_o !== want.ch) report("b64_char", b64_char_o, want.ch);
        if (last_char_o !== want.last) report("last_char", last_char_o, want.last);
      end
    end
  end

  row_t rows[] = '{
    '{'{8'h00, 1'b0, 1'b0}, ""},                               // idle item
    '{'{8'h00, 1'b0, 1'b1}, "2jmj7l5rSw0yVb/vlWAYkK/YBwk="},   // empty message
    '{'{8'h61, 1'b1, 1'b0}, ""},
    '{'{8'h62, 1'b1, 1'b0}, ""},
    '{'{8'h63, 1'b1, 1'b1}, "qZk+NkcGgWq6PiVxeFDCbJzQ2J0="},   // closing byte
    '{'{8'hFF, 1'b1, 1'b0}, ""},
    '{'{8'h00, 1'b0, 1'b0}, ""},
    '{'{8'h00, 1'b1, 1'b0}, ""},
    '{'{8'hFF, 1'b1, 1'b1}, ""},
    '{'{8'h00, 1'b1, 1'b1}, ""},
    '{'{8'h00, 1'b0, 1'b1}, "2jmj7l5rSw0yVb/vlWAYkK/YBwk="}
  };

  initial begin
    int n_items;
    int len;
    int wait_cycles;
    sdb64_pkg::item_t it;
    hash_init();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send(rows[i].item, rows[i].digest);

    n_items = 0;
    while (n_items < 230) begin
      calm = (n_items >= 110 && n_items < 170);
      // lengths around the padding and block edges, otherwise short
      if ($urandom_range(2) == 0) len = 54 + $urandom_range(12);
      else len = $urandom_range(20);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(15) == 0) send('{8'($urandom), 1'b0, 1'b0}, "");
        it = '{8'($urandom), 1'b1, 1'b0};
        if (b == len - 1 && $urandom_range(1)) it.eom = 1'b1;
        send(it, "");
        n_items++;
      end
      if (!it.eom || len == 0) begin
        send('{8'($urandom), 1'b0, 1'b1}, "");
        n_items++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (digest_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (400) @(posedge clk_i);
    if (digest_q.size() != 0) report("missing chars", digest_q.size(), 0);

    $display("%0d messages hashed, %0d message bytes, padding and block edges crossed",
             msgs_done, bytes_sent);
    if (errors == 0) $display("[sha1_digest_base64_core] OK");
    else $display("[sha1_digest_base64_core] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[sha1_digest_base64_core] ERROR");
    $finish;
  end

endmodule
